FILE: design/pwmcap_pkg.sv
// ----------------------------------------------------------------------------
// pwmcap_pkg
// Shared types and constants of the PWM capture duty and frequency meter.
// ----------------------------------------------------------------------------
package pwmcap_pkg;

  // Capture timer and field widths
  localparam int unsigned TimerWidth  = 16;
  localparam int unsigned PeriodWidth = TimerWidth + 1;
  localparam int unsigned TicksWidth  = 24;
  localparam int unsigned DutyWidth   = 7;

  // Both divisions run on numerators of this width, one bit per step
  localparam int unsigned DivSteps    = TicksWidth;
  localparam int unsigned StepWidth   = $clog2(DivSteps + 1);

  localparam logic [TicksWidth-1:0] TicksReset   = TicksWidth'(1000000);
  localparam logic [DutyWidth-1:0]  PercentScale = DutyWidth'(100);

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // One capture event
  typedef struct packed {
    logic                  edge_rising;
    logic [TimerWidth-1:0] capture_time;
  } in_t;

  // One measurement result
  typedef struct packed {
    logic [TimerWidth-1:0] high_ticks;
    logic [TimerWidth-1:0] low_ticks;
    logic [DutyWidth-1:0]  duty_percent;
    logic [TicksWidth-1:0] freq_hz;
    logic                  period_error;
  } res_t;

  // Completed edge triple, front to back
  typedef struct packed {
    logic [TimerWidth-1:0] high_ticks;
    logic [TimerWidth-1:0] low_ticks;
  } meas_t;

  // Queue status toward its two sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Front edge-sequence phase
  typedef enum logic [1:0] {
    PhWaitRise1,
    PhWaitFall,
    PhWaitRise2
  } phase_e;

  // Back sequencer
  typedef enum logic [1:0] {
    BkIdle,
    BkLoad,
    BkDiv,
    BkDone
  } back_state_e;

endpackage

FILE: design/pwm_capture_duty_freq_meter.sv
// ----------------------------------------------------------------------------
// pwm_capture_duty_freq_meter
// Measures high time, low time, duty and frequency of a PWM signal from
// input-capture events.
// ----------------------------------------------------------------------------
// A pushed capture event is accepted when the queue is not full. After a
// rising, a falling and a second rising edge (wrong-polarity edges are
// ignored) one result is queued; duty and frequency come from two bit-serial
// dividers working side by side, one quotient bit per cycle. A two-entry
// queue sits between edge tracking and the dividers, and the result register
// lets the next result start while one waits to be popped. A zero period
// returns period_error with duty and frequency at zero. ticks_per_second
// resets to 1000000 and may be written only while the block is idle.
module pwm_capture_duty_freq_meter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pwmcap_pkg::TicksWidth-1:0] cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  pwmcap_pkg::in_t                   in_i,
  output logic                              empty,
  input  logic                              pop,
  output pwmcap_pkg::res_t                  res_o
);

  logic [pwmcap_pkg::TicksWidth-1:0] tps_q;
  logic                              accept, front_push, q_pop, res_valid;
  pwmcap_pkg::meas_t                 front_meas, q_meas;
  pwmcap_pkg::qstat_t                q_stat;

  // Tick-rate register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= pwmcap_pkg::TicksReset;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;
  assign empty  = !res_valid;

  pwmcap_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .push_o   (front_push),
    .meas_o   (front_meas)
  );

  pwmcap_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .meas_i (front_meas),
    .pop_i  (q_pop),
    .meas_o (q_meas),
    .stat_o (q_stat)
  );

  pwmcap_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ticks_per_second_i (tps_q),
    .meas_i             (q_meas),
    .qstat_i            (q_stat),
    .qpop_o             (q_pop),
    .res_pop_i          (pop && res_valid),
    .res_valid_o        (res_valid),
    .res_o              (res_o)
  );

endmodule

FILE: design/pwmcap_front.sv
// ----------------------------------------------------------------------------
// pwmcap_front
// Tracks the rise / fall / rise edge sequence and emits high and low times.
// ----------------------------------------------------------------------------
module pwmcap_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  pwmcap_pkg::in_t       in_i,
  output logic                  push_o,
  output pwmcap_pkg::meas_t     meas_o
);

  pwmcap_pkg::phase_e phase_q, phase_d;
  logic [pwmcap_pkg::TimerWidth-1:0] rise_q, rise_d;
  logic [pwmcap_pkg::TimerWidth-1:0] fall_q, fall_d;

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pwmcap_pkg::PhWaitRise1;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Timestamps, always written before use
  always_ff @(posedge clk_i) begin
    rise_q <= rise_d;
    fall_q <= fall_d;
  end

  // Next phase; wrong polarity leaves everything as is
  always_comb begin
    phase_d = phase_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    push_o  = 1'b0;
    unique case (phase_q)
      pwmcap_pkg::PhWaitFall: begin
        if (accept_i && !in_i.edge_rising) begin
          fall_d  = in_i.capture_time;
          phase_d = pwmcap_pkg::PhWaitRise2;
        end
      end
      pwmcap_pkg::PhWaitRise2: begin
        if (accept_i && in_i.edge_rising) begin
          push_o  = 1'b1;
          phase_d = pwmcap_pkg::PhWaitRise1;
        end
      end
      default: begin
        if (accept_i && in_i.edge_rising) begin
          rise_d  = in_i.capture_time;
          phase_d = pwmcap_pkg::PhWaitFall;
        end
      end
    endcase
  end

  // Wrapping timer differences
  assign meas_o.high_ticks = fall_q - rise_q;
  assign meas_o.low_ticks  = in_i.capture_time - fall_q;

endmodule

FILE: design/pwmcap_queue.sv
// ----------------------------------------------------------------------------
// pwmcap_queue
// Short FIFO of measurements between the edge front and the divider back.
// ----------------------------------------------------------------------------
module pwmcap_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pwmcap_pkg::meas_t     meas_i,
  input  logic                  pop_i,
  output pwmcap_pkg::meas_t     meas_o,
  output pwmcap_pkg::qstat_t    stat_o
);

  localparam int unsigned CntW = $clog2(pwmcap_pkg::QueueDepth + 1);

  pwmcap_pkg::meas_t                  slot_q [pwmcap_pkg::QueueDepth];
  logic [pwmcap_pkg::QueuePtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]                    cnt_q;
  logic                               do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(pwmcap_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign meas_o       = slot_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= meas_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Fill count stays within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(pwmcap_pkg::QueueDepth))
    else $error("queue count exceeds depth");

  // A push into a full queue would lose a measurement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push while queue full");

  // Pointers differ by the fill count
  QueuePtrChk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q - rptr_q) == cnt_q[pwmcap_pkg::QueuePtrW-1:0])
    else $error("queue pointers out of step with count");

endmodule

FILE: design/pwmcap_back.sv
// ----------------------------------------------------------------------------
// pwmcap_back
// Computes duty and frequency with two bit-serial dividers, holds the result.
// ----------------------------------------------------------------------------
module pwmcap_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [pwmcap_pkg::TicksWidth-1:0]    ticks_per_second_i,
  input  pwmcap_pkg::meas_t                    meas_i,
  input  pwmcap_pkg::qstat_t                   qstat_i,
  output logic                                 qpop_o,
  input  logic                                 res_pop_i,
  output logic                                 res_valid_o,
  output pwmcap_pkg::res_t                     res_o
);

  localparam int unsigned NumW = pwmcap_pkg::TicksWidth;
  localparam int unsigned RemW = pwmcap_pkg::PeriodWidth;

  pwmcap_pkg::back_state_e state_q, state_d;
  logic [pwmcap_pkg::StepWidth-1:0]  step_q, step_d;
  pwmcap_pkg::meas_t                 meas_q, meas_d;
  logic [RemW-1:0]                   div_q, div_d;
  logic [NumW-1:0]                   numf_q, numf_d, numd_q, numd_d;
  logic [RemW-1:0]                   remf_q, remf_d, remd_q, remd_d;
  logic                              err_q, err_d;
  logic [RemW-1:0]                   period;
  logic [NumW-1:0]                   numf_nx, numd_nx;
  logic [RemW-1:0]                   remf_nx, remd_nx;
  logic                              res_valid_q, res_load;
  pwmcap_pkg::res_t                  res_q;

  // One restoring step: shift in the numerator MSB, subtract if it fits
  function automatic logic [NumW+RemW-1:0] div_step(logic [NumW-1:0] num,
                                                    logic [RemW-1:0] rem,
                                                    logic [RemW-1:0] dvs);
    logic [RemW:0] sh;
    logic [RemW:0] diff;
    sh   = {rem, num[NumW-1]};
    diff = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      div_step = {num[NumW-2:0], 1'b1, diff[RemW-1:0]};
    end else begin
      div_step = {num[NumW-2:0], 1'b0, sh[RemW-1:0]};
    end
  endfunction

  assign period = {1'b0, meas_q.high_ticks} + {1'b0, meas_q.low_ticks};
  assign {numf_nx, remf_nx} = div_step(numf_q, remf_q, div_q);
  assign {numd_nx, remd_nx} = div_step(numd_q, remd_q, div_q);

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwmcap_pkg::BkIdle;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    meas_q <= meas_d;
    div_q  <= div_d;
    numf_q <= numf_d;
    numd_q <= numd_d;
    remf_q <= remf_d;
    remd_q <= remd_d;
    err_q  <= err_d;
    if (res_load) begin
      res_q.high_ticks   <= meas_q.high_ticks;
      res_q.low_ticks    <= meas_q.low_ticks;
      res_q.duty_percent <= err_q ? '0 : numd_q[pwmcap_pkg::DutyWidth-1:0];
      res_q.freq_hz      <= err_q ? '0 : numf_q;
      res_q.period_error <= err_q;
    end
  end

  // Next state: fetch, load operands, divide (skipped for a zero period), hand off
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    meas_d   = meas_q;
    div_d    = div_q;
    numf_d   = numf_q;
    numd_d   = numd_q;
    remf_d   = remf_q;
    remd_d   = remd_q;
    err_d    = err_q;
    qpop_o   = 1'b0;
    res_load = 1'b0;
    unique case (state_q)
      pwmcap_pkg::BkIdle: begin
        if (!qstat_i.empty) begin
          qpop_o  = 1'b1;
          meas_d  = meas_i;
          state_d = pwmcap_pkg::BkLoad;
        end
      end
      pwmcap_pkg::BkLoad: begin
        div_d  = period;
        numf_d = ticks_per_second_i;
        numd_d = NumW'(meas_q.high_ticks) * NumW'(pwmcap_pkg::PercentScale);
        remf_d = '0;
        remd_d = '0;
        step_d = '0;
        err_d  = (period == '0);
        // zero period skips the division
        state_d = (period == '0) ? pwmcap_pkg::BkDone : pwmcap_pkg::BkDiv;
      end
      pwmcap_pkg::BkDiv: begin
        numf_d = numf_nx;
        remf_d = remf_nx;
        numd_d = numd_nx;
        remd_d = remd_nx;
        step_d = step_q + 1'b1;
        if (step_q == pwmcap_pkg::StepWidth'(pwmcap_pkg::DivSteps - 1)) begin
          state_d = pwmcap_pkg::BkDone;
        end
      end
      pwmcap_pkg::BkDone: begin
        if (!res_valid_q || res_pop_i) begin
          res_load = 1'b1;
          state_d  = pwmcap_pkg::BkIdle;
        end
      end
      default: begin
        state_d = pwmcap_pkg::BkIdle;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Step counter never runs past the numerator width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= pwmcap_pkg::StepWidth'(pwmcap_pkg::DivSteps))
    else $error("divider step count overrun");

  // Error results carry zero duty and frequency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.period_error) |-> (res_q.duty_percent == '0 && res_q.freq_hz == '0))
    else $error("period error with nonzero duty or frequency");

  // Duty is a percentage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.duty_percent <= pwmcap_pkg::PercentScale))
    else $error("duty above one hundred percent");

endmodule
